/* hw/rtl/swm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

   // defaults for the top-level parameters
   localparam int WINDOW_MAX_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 32;

   // configuration register file
   localparam int       WINDOW_LEN_BITS    = 7;
   localparam int       CSR_ADDR_BITS      = 3;
   localparam int       CSR_DATA_BITS      = 32;
   localparam logic     CSR_IDX_WINDOW_LEN = 1'b0;
   localparam logic [WINDOW_LEN_BITS-1:0] WINDOW_LEN_RESET = 7'd3;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RING,
      ST_FETCH,
      ST_MERGE,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;        // capture sample, open a new merge pass
      logic ring_access;  // read oldest ring slot, write new sample there
      logic merge_step;   // one step of the remove/insert merge
      logic commit;       // close the pass: counters, bank swap, result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic merge_done;   // all old entries consumed and new sample placed
      logic merge_adv;    // this step moves the read pointer
      logic has_result;   // this pass leaves a full window
   } stat_type;

endpackage

`default_nettype wire

/* hw/rtl/swm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module swm_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output swm_pkg::cmd_type     cmd,
   input  wire swm_pkg::stat_type stat
);
   import swm_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // state and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_RING;
            end
         end
         ST_RING: begin
            cmd.ring_access = 1'b1;
            state_in        = ST_MERGE;
         end
         ST_FETCH: begin
            // sorted memory read data catches up with the read pointer
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (stat.merge_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.merge_step = 1'b1;
               if (stat.merge_adv) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FINISH: begin
            // hold while a previous result is still waiting on the output and this pass has a new one
            if (!(stat.has_result && rsp_valid_ff && rsp_stall)) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
               if (stat.has_result) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hw/rtl/swm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module swm_datapath #(
   parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire swm_pkg::cmd_type                    cmd,
   output swm_pkg::stat_type                        stat,
   input  wire logic                                cfg_clear,
   input  wire logic [swm_pkg::WINDOW_LEN_BITS-1:0] window_len,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic signed [SAMPLE_BITS-1:0]            rsp_median
);
   import swm_pkg::*;

   localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
   localparam int RING_DEPTH = 2 ** IDX_W;
   localparam int SORT_DEPTH = 2 ** (IDX_W + 1);

   // arrival-order ring and the two banks of the sorted copy
   logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] sort_mem [SORT_DEPTH];

   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SAMPLE_BITS-1:0] old_ff;
   logic [SAMPLE_BITS-1:0] sort_rd_ff;
   logic [SAMPLE_BITS-1:0] capture_ff;
   logic [SAMPLE_BITS-1:0] median_ff;
   logic [CNT_W-1:0]       fill_ff;
   logic [CNT_W-1:0]       fill_in;
   logic [IDX_W-1:0]       oldest_ff;
   logic [IDX_W-1:0]       oldest_in;
   logic                   bank_ff;
   logic [CNT_W-1:0]       rd_ptr_ff;
   logic [CNT_W-1:0]       wr_ptr_ff;
   logic                   rm_pend_ff;
   logic                   ins_done_ff;

   logic [31:0]            len_wide;
   logic [CNT_W-1:0]       eff_len;
   logic [CNT_W-1:0]       mid_pos;
   logic [CNT_W-1:0]       oldest_inc;
   logic                   full;
   logic                   rd_end;
   logic                   take_rm;
   logic                   take_x;
   logic                   wr_en;
   logic [SAMPLE_BITS-1:0] wr_data;

   // effective window length: zero acts as one, saturate at the maximum
   always_comb begin
      len_wide = 32'(window_len);
      if (len_wide == 32'd0) begin
         eff_len = CNT_W'(1);
      end else if (len_wide > 32'(WINDOW_MAX)) begin
         eff_len = CNT_W'(WINDOW_MAX);
      end else begin
         eff_len = CNT_W'(len_wide);
      end
   end

   assign mid_pos = (eff_len - CNT_W'(1)) >> 1;
   assign full    = (fill_ff == eff_len);

   // merge step decision: drop one copy of the evicted value, place the new one
   assign rd_end  = (rd_ptr_ff == fill_ff);
   assign take_rm = rm_pend_ff && !rd_end && (sort_rd_ff == old_ff);
   assign take_x  = !take_rm && !ins_done_ff &&
                    (rd_end || ($signed(sort_rd_ff) > $signed(sample_ff)));
   assign wr_en   = cmd.merge_step && !take_rm;
   assign wr_data = take_x ? sample_ff : sort_rd_ff;

   assign stat.merge_done = rd_end && ins_done_ff;
   assign stat.merge_adv  = !take_x;
   assign stat.has_result = full || ((fill_ff + CNT_W'(1)) == eff_len);

   // counters after the pass
   assign fill_in    = full ? fill_ff : fill_ff + CNT_W'(1);
   assign oldest_inc = CNT_W'(oldest_ff) + CNT_W'(1);
   assign oldest_in  = (oldest_inc >= eff_len) ? '0 : IDX_W'(oldest_inc);

   // ring memory: read old value and write new sample in the same cycle
   always_ff @(posedge clock) begin
      if (cmd.ring_access) begin
         old_ff              <= ring_mem[oldest_ff];
         ring_mem[oldest_ff] <= sample_ff;
      end
   end

   // sorted memory: read the current bank, write the other one
   always_ff @(posedge clock) begin
      sort_rd_ff <= sort_mem[{bank_ff, rd_ptr_ff[IDX_W-1:0]}];
      if (wr_en) begin
         sort_mem[{~bank_ff, wr_ptr_ff[IDX_W-1:0]}] <= wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sample_ff <= req_sample;
      end
      if (wr_en && (wr_ptr_ff == mid_pos)) begin
         capture_ff <= wr_data;
      end
      if (cmd.commit && stat.has_result) begin
         median_ff <= capture_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         oldest_ff   <= '0;
         bank_ff     <= 1'b0;
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         rm_pend_ff  <= 1'b0;
         ins_done_ff <= 1'b0;
      end else if (cfg_clear) begin
         fill_ff   <= '0;
         oldest_ff <= '0;
      end else begin
         if (cmd.start) begin
            rd_ptr_ff   <= '0;
            wr_ptr_ff   <= '0;
            rm_pend_ff  <= full;
            ins_done_ff <= 1'b0;
         end
         if (cmd.merge_step) begin
            if (take_rm) begin
               rm_pend_ff <= 1'b0;
               rd_ptr_ff  <= rd_ptr_ff + CNT_W'(1);
            end else if (take_x) begin
               ins_done_ff <= 1'b1;
               wr_ptr_ff   <= wr_ptr_ff + CNT_W'(1);
            end else begin
               rd_ptr_ff <= rd_ptr_ff + CNT_W'(1);
               wr_ptr_ff <= wr_ptr_ff + CNT_W'(1);
            end
         end
         if (cmd.commit) begin
            fill_ff   <= fill_in;
            oldest_ff <= oldest_in;
            bank_ff   <= ~bank_ff;
         end
      end
   end

   assign rsp_median = median_ff;

endmodule

`default_nettype wire

/* hw/rtl/sliding_window_median.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_sample
// rsp       out        rsp_valid/rsp_stall   rsp_median
// csr       in         csr_psel/csr_penable  csr_paddr, csr_pwdata, csr_prdata
//
// One sample at a time: accept, ring access, then a merge pass over the sorted
// copy, with a fetch state after each step that moves the read pointer so the
// sorted-memory read data can catch up.
// Synchronous active-high reset empties the window; the memories are not cleared.
// A waiting result does not block the next sample; only a second result stalls.
// A write to window_len empties the window.

module sliding_window_median #(
   parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]     req_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_median,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [swm_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [swm_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [swm_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                   csr_pready
);
   import swm_pkg::*;

   logic [WINDOW_LEN_BITS-1:0] window_len_ff;
   logic                       csr_wr;
   logic                       cfg_clear;
   cmd_type                    cmd;
   stat_type                   stat;

   // register file write and read
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_clear  = csr_wr && (csr_paddr[2] == CSR_IDX_WINDOW_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_LEN_RESET;
      end else if (cfg_clear) begin
         window_len_ff <= csr_pwdata[WINDOW_LEN_BITS-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_WINDOW_LEN) ?
                       CSR_DATA_BITS'(window_len_ff) : '0;

   // sequencer
   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // ring, sorted banks and merge logic
   swm_datapath #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cfg_clear  (cfg_clear),
      .window_len (window_len_ff),
      .req_sample (req_sample),
      .rsp_median (rsp_median)
   );

   // a sample transfer starts a pass, so no second one follows at once
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sample accepted while a pass was starting");

   // a new result only appears right after a pass is closed
   a_result_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("result raised without a committed pass");

   // the sequencer issues at most one command per cycle
   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.ring_access, cmd.merge_step, cmd.commit}))
      else $error("more than one datapath command");

endmodule

`default_nettype wire
